/* rtl/bgd_pkg.sv */
// Shared types and constants for the button gesture debouncer.
// No dependencies; used by the top level and its port checker.
package bgd_pkg;

    // Gesture event codes carried in the result tdata
    typedef logic [2:0] t_event;

    localparam t_event EV_NONE         = 3'd0;
    localparam t_event EV_LONG_START   = 3'd1;
    localparam t_event EV_LONG_RELEASE = 3'd2;
    localparam t_event EV_SINGLE       = 3'd3;
    localparam t_event EV_DOUBLE       = 3'd4;

    // Register map: word index taken from paddr[3:2]
    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_DEBOUNCE     = 2'd0;
    localparam t_reg_idx REG_LONG_PRESS   = 2'd1;
    localparam t_reg_idx REG_DOUBLE_CLICK = 2'd2;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned TIME_W = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd800;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd300;

    // Stream widths: fields packed from bit 0, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 8;

endpackage

/* rtl/button_gesture_debouncer_top.sv */
// Button gesture debouncer: debounce filter plus single/double/long press detector.
// Depends on bgd_pkg (codes, widths, reset values).
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  -----------------------------------------
//  s_axis    in   tvalid/tready             tdata[0] button_pressed, [32:1] now_ms
//  m_axis    out  tvalid/tready             tdata[2:0] gesture_event
//  apb       in   psel/penable/pwrite       regs 0x0 debounce, 0x4 long press, 0x8 gap
//
// One poll request is taken every cycle while m_axis is not stalling; its gesture
// event is held in the output register from the next cycle. The whole update (two
// 32-bit wrapping subtractions, their compares and the five-state machine) fits
// between the input and the result register. s_axis_tready drops only while a
// result is held and m_axis stalls. Reset is synchronous, active low, and leaves a
// released button at time 0 with the default thresholds.
module button_gesture_debouncer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // poll request
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bgd_pkg::IN_TDATA_W-1:0]       s_axis_tdata,   // [0] button_pressed, [32:1] now_ms
    // gesture result
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bgd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [2:0] gesture_event
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [bgd_pkg::ADDR_W-1:0]           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    typedef enum logic [2:0] {
        GS_IDLE   = 3'd0,
        GS_PRESS1 = 3'd1,
        GS_LONG   = 3'd2,
        GS_GAP    = 3'd3,
        GS_PRESS2 = 3'd4
    } t_gstate;

    localparam int unsigned TW = bgd_pkg::TIME_W;
    localparam int unsigned CW = bgd_pkg::CFG_W;

    // configuration registers
    logic [CW-1:0] r_debounce, r_long_press, r_double_click;

    // debounce and gesture state
    logic          r_last_raw, n_last_raw;
    logic          r_stable, n_stable;
    logic [TW-1:0] r_change_time, n_change_time;
    t_gstate       r_state, n_state;
    logic [TW-1:0] r_entry_time, n_entry_time;

    // result register
    logic              r_out_valid;
    bgd_pkg::t_event   r_out_event, n_event;

    logic          in_fire;
    logic          raw;
    logic [TW-1:0] now;
    logic [TW-1:0] deb_elapsed, state_elapsed;
    logic          edge_fire, press_edge, release_edge;
    logic          long_due, gap_due;
    logic          cfg_wr;
    bgd_pkg::t_reg_idx cfg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        case (cfg_idx)
            bgd_pkg::REG_DEBOUNCE:     prdata = {16'd0, r_debounce};
            bgd_pkg::REG_LONG_PRESS:   prdata = {16'd0, r_long_press};
            bgd_pkg::REG_DOUBLE_CLICK: prdata = {16'd0, r_double_click};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce     <= bgd_pkg::DEBOUNCE_RST;
            r_long_press   <= bgd_pkg::LONG_PRESS_RST;
            r_double_click <= bgd_pkg::DOUBLE_CLICK_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                bgd_pkg::REG_DEBOUNCE:     r_debounce     <= pwdata[CW-1:0];
                bgd_pkg::REG_LONG_PRESS:   r_long_press   <= pwdata[CW-1:0];
                bgd_pkg::REG_DOUBLE_CLICK: r_double_click <= pwdata[CW-1:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

    // ---------------- stream handshake ----------------
    // Take a new poll whenever the result register is empty or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign raw = s_axis_tdata[0];
    assign now = s_axis_tdata[TW:1];

    // ---------------- debounce filter ----------------
    // Restart the debounce timer on every raw change, then flip the stable
    // level once the raw level disagrees with it for long enough.
    always_comb begin
        n_last_raw    = raw;
        n_change_time = (raw != r_last_raw) ? now : r_change_time;
        deb_elapsed   = now - n_change_time;
        edge_fire     = (raw != r_stable) && (deb_elapsed >= {16'd0, r_debounce});
        n_stable      = edge_fire ? raw : r_stable;
    end

    assign press_edge   = edge_fire && raw;
    assign release_edge = edge_fire && !raw;

    // Elapsed time in the current gesture state, wrapping subtraction.
    assign state_elapsed = now - r_entry_time;
    assign long_due      = state_elapsed >= {16'd0, r_long_press};
    assign gap_due       = state_elapsed >= {16'd0, r_double_click};

    // ---------------- gesture machine ----------------
    always_comb begin
        n_state      = r_state;
        n_entry_time = r_entry_time;
        n_event      = bgd_pkg::EV_NONE;
        case (r_state)
            GS_PRESS1: begin
                if (release_edge) begin
                    n_state      = GS_GAP;
                    n_entry_time = now;
                end else if (long_due) begin
                    n_state = GS_LONG;
                    n_event = bgd_pkg::EV_LONG_START;
                end
            end
            GS_LONG: begin
                if (release_edge) begin
                    n_state = GS_IDLE;
                    n_event = bgd_pkg::EV_LONG_RELEASE;
                end
            end
            GS_GAP: begin
                if (press_edge) begin
                    n_state      = GS_PRESS2;
                    n_entry_time = now;
                end else if (gap_due) begin
                    n_state = GS_IDLE;
                    n_event = bgd_pkg::EV_SINGLE;
                end
            end
            GS_PRESS2: begin
                if (release_edge) begin
                    n_state = GS_IDLE;
                    n_event = bgd_pkg::EV_DOUBLE;
                end
            end
            default: begin
                // idle, and any code that should never appear
                if (press_edge) begin
                    n_state      = GS_PRESS1;
                    n_entry_time = now;
                end
            end
        endcase
    end

    // ---------------- state and result registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_change_time <= '0;
            r_state       <= GS_IDLE;
            r_entry_time  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                // advance all state on an accepted poll
                r_last_raw    <= n_last_raw;
                r_stable      <= n_stable;
                r_change_time <= n_change_time;
                r_state       <= n_state;
                r_entry_time  <= n_entry_time;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload holds until the next accepted poll
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_event <= n_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_event};

endmodule

/* rtl/bgd_checker.sv */
// Port-level checker for the button gesture debouncer, bound to the top level.
// Depends on bgd_pkg (event codes, widths).
module bgd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [bgd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // every accepted poll yields a result in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted poll produced no result");

    // never stall the input while the output side is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // only defined event codes leave the block
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= bgd_pkg::EV_DOUBLE
                           && m_axis_tdata[7:3] == 5'd0))
        else $error("undefined gesture event code");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind button_gesture_debouncer_top bgd_checker u_bgd_checker (.*);

/* test/gesture_scoreboard_pkg.sv */
// Scoreboard for the button gesture debouncer bench: predicts the gesture event
// of each accepted poll request and checks the results in order.
// Depends on bgd_pkg for event codes, register indexes and widths.
package gesture_scoreboard_pkg;

    typedef enum logic [2:0] {
        GS_IDLE   = 3'd0,
        GS_PRESS1 = 3'd1,
        GS_LONG   = 3'd2,
        GS_GAP    = 3'd3,
        GS_PRESS2 = 3'd4
    } t_gesture_state;

    class gesture_scoreboard;
        logic [bgd_pkg::CFG_W-1:0]  debounce_ms;
        logic [bgd_pkg::CFG_W-1:0]  long_press_ms;
        logic [bgd_pkg::CFG_W-1:0]  double_click_ms;
        bit                         last_raw;
        bit                         stable_lvl;
        logic [bgd_pkg::TIME_W-1:0] raw_change_t;
        logic [bgd_pkg::TIME_W-1:0] entry_t;
        t_gesture_state             gstate;
        bgd_pkg::t_event            pending_events[$];
        int unsigned                polls;
        int unsigned                errors;

        function new();
            debounce_ms     = bgd_pkg::DEBOUNCE_RST;
            long_press_ms   = bgd_pkg::LONG_PRESS_RST;
            double_click_ms = bgd_pkg::DOUBLE_CLICK_RST;
            last_raw        = 1'b0;
            stable_lvl      = 1'b0;
            raw_change_t    = '0;
            entry_t         = '0;
            gstate          = GS_IDLE;
            polls           = 0;
            errors          = 0;
        endfunction

        function void write_reg(bgd_pkg::t_reg_idx idx, logic [31:0] word);
            case (idx)
                bgd_pkg::REG_DEBOUNCE:     debounce_ms     = word[bgd_pkg::CFG_W-1:0];
                bgd_pkg::REG_LONG_PRESS:   long_press_ms   = word[bgd_pkg::CFG_W-1:0];
                bgd_pkg::REG_DOUBLE_CLICK: double_click_ms = word[bgd_pkg::CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_events.size();
        endfunction

        // Advance the debounce filter and the gesture machine by one poll.
        function void note_poll(bit raw, logic [bgd_pkg::TIME_W-1:0] now);
            logic [bgd_pkg::TIME_W-1:0] held;
            logic [bgd_pkg::TIME_W-1:0] in_state;
            bit                         flip;
            bgd_pkg::t_event            ev;
            ev   = bgd_pkg::EV_NONE;
            flip = 1'b0;
            if (raw != last_raw) begin
                last_raw     = raw;
                raw_change_t = now;
            end
            held = now - raw_change_t;
            if (raw != stable_lvl && held >= {16'd0, debounce_ms}) begin
                stable_lvl = raw;
                flip       = 1'b1;
            end
            in_state = now - entry_t;
            case (gstate)
                GS_PRESS1: begin
                    if (flip && !stable_lvl) begin
                        gstate  = GS_GAP;
                        entry_t = now;
                    end else if (in_state >= {16'd0, long_press_ms}) begin
                        gstate = GS_LONG;
                        ev     = bgd_pkg::EV_LONG_START;
                    end
                end
                GS_LONG: begin
                    if (flip && !stable_lvl) begin
                        gstate = GS_IDLE;
                        ev     = bgd_pkg::EV_LONG_RELEASE;
                    end
                end
                GS_GAP: begin
                    if (flip && stable_lvl) begin
                        gstate  = GS_PRESS2;
                        entry_t = now;
                    end else if (in_state >= {16'd0, double_click_ms}) begin
                        gstate = GS_IDLE;
                        ev     = bgd_pkg::EV_SINGLE;
                    end
                end
                GS_PRESS2: begin
                    if (flip && !stable_lvl) begin
                        gstate = GS_IDLE;
                        ev     = bgd_pkg::EV_DOUBLE;
                    end
                end
                default: begin
                    if (flip && stable_lvl) begin
                        gstate  = GS_PRESS1;
                        entry_t = now;
                    end
                end
            endcase
            pending_events.push_back(ev);
            polls++;
        endfunction

        task check_result(logic [bgd_pkg::OUT_TDATA_W-1:0] tdata);
            bgd_pkg::t_event want;
            if (pending_events.size() == 0) begin
                report($sformatf("event 0x%0h arrived with no poll pending", tdata));
            end else begin
                want = pending_events.pop_front();
                if (tdata !== {{(bgd_pkg::OUT_TDATA_W-3){1'b0}}, want}) begin
                    report($sformatf("gesture event 0x%0h, predicted %0d", tdata, want));
                end
            end
        endtask

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask
    endclass

endpackage

/* test/tb.sv */
// Bench top for button_gesture_debouncer_top: drives poll requests and APB writes,
// predicts each gesture event in gesture_scoreboard_pkg and checks it.
// Depends on bgd_pkg and gesture_scoreboard_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_POLLS    = 1850;
    localparam int unsigned LIMIT_CYCLES    = 1_000_000;
    localparam int unsigned PRESSURE_AT     = 600;
    localparam int unsigned PRESSURE_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES     = 4;
    localparam int unsigned CW              = bgd_pkg::CFG_W;
    localparam int unsigned TW              = bgd_pkg::TIME_W;
    localparam int unsigned IW              = bgd_pkg::IN_TDATA_W;
    // index with no register behind it: writes must be dropped
    localparam bgd_pkg::t_reg_idx REG_SPARE = 2'd3;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [IW-1:0]                      s_axis_tdata  = '0; // [0] button_pressed, [32:1] now_ms
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [bgd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;       // [2:0] gesture_event
    logic                               psel          = 1'b0;
    logic                               penable       = 1'b0;
    logic                               pwrite        = 1'b0;
    logic [bgd_pkg::ADDR_W-1:0]         paddr         = '0;
    logic [31:0]                        pwdata        = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    gesture_scoreboard_pkg::gesture_scoreboard sb = new();

    bit                bit_unused_guard;
    bit                burst_mode    = 1'b0;   // no idling on either side
    bit                pressure_done = 1'b0;
    logic [TW-1:0]     t_now         = '0;     // running millisecond clock of the button
    int unsigned       coarse_step   = 1;
    int unsigned       cycle_count   = 0;

    button_gesture_debouncer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        if (burst_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Time step between polls: sometimes fine enough to land inside the
    // debounce window, otherwise scaled to the widest threshold.
    function automatic int unsigned time_step();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, sb.debounce_ms / 2 + 1);
        return $urandom_range(0, coarse_step);
    endfunction

    // Offer one poll request; enter and leave at a falling edge with tvalid
    // still high, so a back-to-back request needs no second assignment.
    task automatic send_poll(bit raw, logic [TW-1:0] now);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IW - TW - 1){1'b0}}, now, raw};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_poll(raw, now);
        @(negedge i_clk);
    endtask

    // Drop the request line; call right after send_poll returns.
    task automatic stream_pause();
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait until every predicted event has come back; leave at a falling edge.
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready. Upper data bits
    // carry junk that the register must ignore.
    task automatic cfg_write(bgd_pkg::t_reg_idx idx, logic [CW-1:0] value);
        logic [31:0] word;
        word = {16'($urandom()), value};
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, word);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the button at one level for about span ms, optionally with contact
    // bounce at the start.
    task automatic play_level(bit lvl, int unsigned span);
        int unsigned elapsed;
        int unsigned jitter;
        int unsigned step;
        jitter = sb.debounce_ms / 2;
        if (sb.debounce_ms >= 2 && $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) begin
                send_poll(lvl, t_now);
                t_now += $urandom_range(0, jitter);
                send_poll(!lvl, t_now);
                t_now += $urandom_range(0, jitter);
            end
        end
        elapsed = 0;
        send_poll(lvl, t_now);
        while (elapsed < span) begin
            step     = time_step();
            t_now   += step;
            elapsed += step;
            send_poll(lvl, t_now);
        end
    endtask

    // Noise: random levels, random jumps of the clock, backwards steps.
    task automatic play_noise();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 2))
                0:       t_now = $urandom();
                1:       t_now -= $urandom_range(0, 2 * coarse_step);
                default: t_now += $urandom_range(0, coarse_step);
            endcase
            send_poll(bit'($urandom_range(0, 1)), t_now);
        end
    endtask

    // Check every result the block hands over, in order.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // Result side: random stalls, plus one long hold-off while the sender keeps
    // offering, so the output register fills and tready on the input drops.
    initial begin
        int unsigned stall;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && sb.polls >= PRESSURE_AT && s_axis_tvalid) begin
                pressure_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                stall = idle_len();
                if (stall != 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned target;
        int unsigned widest;
        int unsigned deb;
        int unsigned lng;
        int unsigned dbl;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds. Long press: debounce, long start, long release.
        send_poll(1'b1, 32'd100);
        send_poll(1'b1, 32'd130);
        send_poll(1'b1, 32'd930);
        send_poll(1'b0, 32'd1000);
        send_poll(1'b0, 32'd1030);
        // double click
        send_poll(1'b1, 32'd2000);
        send_poll(1'b1, 32'd2030);
        send_poll(1'b0, 32'd2100);
        send_poll(1'b0, 32'd2130);
        send_poll(1'b1, 32'd2200);
        send_poll(1'b1, 32'd2230);
        send_poll(1'b0, 32'd2300);
        send_poll(1'b0, 32'd2330);
        // clock running backwards: the wrapped difference meets every threshold
        send_poll(1'b1, 32'd5000);
        send_poll(1'b1, 32'd5030);
        send_poll(1'b0, 32'd5040);
        send_poll(1'b0, 32'd10);
        send_poll(1'b0, 32'd5);
        // debounce across the 2^32 wrap
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b1, 32'h0000_000E);

        // Zero thresholds act at once; the spare index must change nothing.
        stream_pause();
        drain();
        cfg_write(bgd_pkg::REG_DEBOUNCE, '0);
        cfg_write(bgd_pkg::REG_LONG_PRESS, '0);
        cfg_write(bgd_pkg::REG_DOUBLE_CLICK, '0);
        cfg_write(REG_SPARE, 16'hFFFF);
        send_poll(1'b0, 32'd7000);
        send_poll(1'b0, 32'd7000);
        send_poll(1'b1, 32'd7001);
        send_poll(1'b1, 32'd7001);
        send_poll(1'b0, 32'd7001);
        send_poll(1'b1, 32'd7002);
        send_poll(1'b0, 32'd7002);
        send_poll(1'b1, 32'd7002);
        send_poll(1'b0, 32'd7003);
        t_now = 32'd7003;

        // Random phases: new thresholds while idle, then button gestures.
        target = sb.polls + RANDOM_POLLS;
        phase  = 0;
        while (sb.polls < target) begin
            stream_pause();
            drain();
            case (phase)
                0: begin
                    deb = 0;     lng = 0;     dbl = 0;
                end
                1: begin
                    deb = 65535; lng = 65535; dbl = 65535;
                end
                2: begin
                    deb = 65535; lng = 0;     dbl = 65535;
                end
                3: begin
                    deb = 0;     lng = 65535; dbl = 0;
                end
                4: begin
                    deb = bgd_pkg::DEBOUNCE_RST;
                    lng = bgd_pkg::LONG_PRESS_RST;
                    dbl = bgd_pkg::DOUBLE_CLICK_RST;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        deb = $urandom_range(0, 65535);
                        lng = $urandom_range(0, 65535);
                        dbl = $urandom_range(0, 65535);
                    end else begin
                        deb = $urandom_range(0, 20);
                        lng = $urandom_range(0, 300);
                        dbl = $urandom_range(0, 150);
                    end
                end
            endcase
            cfg_write(bgd_pkg::REG_DEBOUNCE, CW'(deb));
            cfg_write(bgd_pkg::REG_LONG_PRESS, CW'(lng));
            cfg_write(bgd_pkg::REG_DOUBLE_CLICK, CW'(dbl));
            if (phase % 3 == 0) begin
                cfg_write(REG_SPARE, 16'($urandom()));
            end

            widest = deb;
            if (lng > widest) widest = lng;
            if (dbl > widest) widest = dbl;
            coarse_step = widest / 4 + 1;
            burst_mode  = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0:       t_now = 32'hFFFF_FFFF - $urandom_range(0, 4 * coarse_step);
                1:       t_now = $urandom();
                default: ;
            endcase

            // press then release, each about half the time past its threshold
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 9) == 0) begin
                    play_noise();
                end else begin
                    play_level(1'b1, $urandom_range(0, 2 * (lng + deb) + coarse_step));
                    play_level(1'b0, $urandom_range(0, 2 * (dbl + deb) + coarse_step));
                end
            end
            phase++;
        end

        burst_mode = 1'b0;
        stream_pause();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* button_gesture_debouncer_top.f */
rtl/bgd_pkg.sv
rtl/button_gesture_debouncer_top.sv
rtl/bgd_checker.sv
test/gesture_scoreboard_pkg.sv
test/tb.sv
